FILE: hw/rtl/lce_pkg.sv
package lce_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TickW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] ZeroHighRst  = 8'd8;
  localparam logic [ByteW-1:0] OneHighRst   = 8'd16;
  localparam logic [ByteW-1:0] BitTicksRst  = 8'd25;
  localparam logic [TickW-1:0] ResetTicksRst = 16'd1600;

  // Item function codes.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_PUSH = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ZERO_HIGH   = 2'd0,
    REG_ONE_HIGH    = 2'd1,
    REG_BIT_TICKS   = 2'd2,
    REG_RESET_TICKS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic ready_res;
    logic busy_res;
    logic overrun;
    logic underrun;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] zero_high_ticks;
    logic [ByteW-1:0] one_high_ticks;
    logic [ByteW-1:0] bit_ticks;
    logic [TickW-1:0] reset_ticks;
  } timing_cfg_t;

endpackage

FILE: hw/rtl/lce_cfg.sv
module lce_cfg
  import lce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data,
  output timing_cfg_t        timing
);

  timing_cfg_t timing_r;

  assign cfg_ready = 1'b1;
  assign timing    = timing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.zero_high_ticks <= ZeroHighRst;
      timing_r.one_high_ticks  <= OneHighRst;
      timing_r.bit_ticks       <= BitTicksRst;
      timing_r.reset_ticks     <= ResetTicksRst;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ZERO_HIGH:   timing_r.zero_high_ticks <= cfg_data[ByteW-1:0];
        REG_ONE_HIGH:    timing_r.one_high_ticks  <= cfg_data[ByteW-1:0];
        REG_BIT_TICKS:   timing_r.bit_ticks       <= cfg_data[ByteW-1:0];
        REG_RESET_TICKS: timing_r.reset_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/lce_core.sv
module lce_core
  import lce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  in_item_t    item,
  input  timing_cfg_t timing,
  output out_item_t   result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_BIT   = 2'd2
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] shift_r, shift_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [ByteW-1:0] hold_byte_r, hold_byte_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  logic             hold_last_r, hold_last_nxt;
  logic             cur_last_r, cur_last_nxt;
  logic             line_r, line_nxt;

  logic [TickW-1:0] tick_inc;
  logic [ByteW-1:0] high_ticks;
  logic             ovr, unr;

  assign tick_inc   = tick_r + 16'd1;
  assign high_ticks = shift_r[bit_idx_r] ? timing.one_high_ticks : timing.zero_high_ticks;

  always_comb begin
    phase_nxt      = phase_r;
    shift_nxt      = shift_r;
    bit_idx_nxt    = bit_idx_r;
    tick_nxt       = tick_r;
    hold_byte_nxt  = hold_byte_r;
    hold_valid_nxt = hold_valid_r;
    hold_last_nxt  = hold_last_r;
    cur_last_nxt   = cur_last_r;
    line_nxt       = line_r;
    ovr            = 1'b0;
    unr            = 1'b0;

    if (item.func == FUNC_PUSH) begin
      if (hold_valid_r) begin
        ovr = 1'b1;
      end else begin
        hold_byte_nxt  = item.data_byte;
        hold_last_nxt  = item.last_byte;
        hold_valid_nxt = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_RESET: begin
          line_nxt = 1'b0;
          if (tick_inc >= timing.reset_ticks) begin
            phase_nxt   = PH_BIT;
            tick_nxt    = '0;
            bit_idx_nxt = 3'd7;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        PH_BIT: begin
          line_nxt = (tick_r < {{(TickW-ByteW){1'b0}}, high_ticks});
          if (tick_inc >= {{(TickW-ByteW){1'b0}}, timing.bit_ticks}) begin
            tick_nxt = '0;
            if (bit_idx_r != 3'd0) begin
              bit_idx_nxt = bit_idx_r - 3'd1;
            end else if (cur_last_r) begin
              phase_nxt = PH_IDLE;
            end else if (hold_valid_r) begin
              // Next byte follows with no gap.
              shift_nxt      = hold_byte_r;
              cur_last_nxt   = hold_last_r;
              hold_valid_nxt = 1'b0;
              bit_idx_nxt    = 3'd7;
            end else begin
              unr       = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end else begin
            tick_nxt = tick_inc;
          end
        end
        default: begin
          // Idle, and the unused phase code, which behaves the same.
          phase_nxt = PH_IDLE;
          line_nxt  = 1'b0;
          if (hold_valid_r) begin
            shift_nxt      = hold_byte_r;
            cur_last_nxt   = hold_last_r;
            hold_valid_nxt = 1'b0;
            bit_idx_nxt    = 3'd7;
            // This tick already counts as the first tick of the reset phase.
            if (16'd1 >= timing.reset_ticks) begin
              phase_nxt = PH_BIT;
              tick_nxt  = '0;
            end else begin
              phase_nxt = PH_RESET;
              tick_nxt  = 16'd1;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    result.line_level = line_nxt;
    result.ready_res  = ~hold_valid_nxt;
    result.busy_res   = (phase_nxt == PH_RESET) || (phase_nxt == PH_BIT);
    result.overrun    = ovr;
    result.underrun   = unr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      shift_r      <= '0;
      bit_idx_r    <= '0;
      tick_r       <= '0;
      hold_byte_r  <= '0;
      hold_valid_r <= 1'b0;
      hold_last_r  <= 1'b0;
      cur_last_r   <= 1'b0;
      line_r       <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      shift_r      <= shift_nxt;
      bit_idx_r    <= bit_idx_nxt;
      tick_r       <= tick_nxt;
      hold_byte_r  <= hold_byte_nxt;
      hold_valid_r <= hold_valid_nxt;
      hold_last_r  <= hold_last_nxt;
      cur_last_r   <= cur_last_nxt;
      line_r       <= line_nxt;
    end
  end

endmodule

FILE: hw/rtl/led_chain_serial_encoder.sv
// One-wire LED chain data line encoder.
// Input channel (in_valid / in_stall / in_data): each beat is either a tick,
// which advances the waveform by one time step, or a push, which loads one
// color byte and its last-of-frame mark into a one-byte holding register.
// Output channel (out_valid / out_stall / out_data): exactly one result beat
// per input beat, in order, giving the line level, holder empty, busy,
// overrun and underrun flags.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): four timing
// registers; the user must write them only while no beat is in flight, which
// the block does not enforce; cfg_ready is always high. A beat lands in the
// input register, is processed into the output register and is offered from
// there. Throughput is one beat per cycle while out_stall is low, set by the
// single step of the encoder state between the input and output registers.
// When out_stall is high the output register holds its beat, the input
// register fills, and in_stall rises once both are occupied.
// Synchronous reset clears the pipeline, the encoder state and the timing
// registers to their defaults; the line is low and the block idle after it.
module led_chain_serial_encoder
  import lce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_data
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  logic        advance;
  timing_cfg_t timing;
  out_item_t   step_res;

  // The held beat moves on when the output register is free or being taken.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  lce_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  lce_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .timing  (timing),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= step_res;
    end
  end

endmodule

FILE: bench/tb_led_chain_serial_encoder.sv
`timescale 1ns / 100ps

module tb_led_chain_serial_encoder;
  import lce_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int LongHold = 80;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 225;

  localparam out_item_t IdleLine =
    '{line_level: 1'b0, ready_res: 1'b1, busy_res: 1'b0, overrun: 1'b0, underrun: 1'b0};
  localparam out_item_t HeldByte =
    '{line_level: 1'b0, ready_res: 1'b0, busy_res: 1'b0, overrun: 1'b0, underrun: 1'b0};
  localparam out_item_t Dropped =
    '{line_level: 1'b0, ready_res: 1'b0, busy_res: 1'b0, overrun: 1'b1, underrun: 1'b0};
  localparam out_item_t FrameStart =
    '{line_level: 1'b0, ready_res: 1'b1, busy_res: 1'b1, overrun: 1'b0, underrun: 1'b0};

  typedef enum logic [1:0] {
    ENC_IDLE  = 2'd0,
    ENC_RESET = 2'd1,
    ENC_SEND  = 2'd2
  } enc_state_e;

  typedef struct packed {
    logic       is_cfg;
    cfg_idx_t   reg_sel;
    logic [15:0] reg_val;
    in_item_t   beat;
    logic [7:0] reps;
    logic       typed;
    out_item_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TickW-1:0] cfg_data;

  always #1 clk = ~clk;

  led_chain_serial_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Encoder model state, kept in step with every accepted beat.
  timing_cfg_t timing;
  enc_state_e enc_phase;
  logic [7:0] enc_shift;
  logic [2:0] enc_bit_idx;
  logic [15:0] enc_ticks;
  logic [7:0] hold_byte;
  logic hold_full;
  logic hold_last;
  logic cur_last;
  logic line_q;

  out_item_t line_beats_due[$];
  dir_row_t dir_rows[$];
  int n_fail = 0;
  int cycles = 0;
  int burst_left = 0;
  logic long_hold_req = 1'b0;

  function automatic void reset_encoder_model();
    timing = '{zero_high_ticks: ZeroHighRst, one_high_ticks: OneHighRst,
               bit_ticks: BitTicksRst, reset_ticks: ResetTicksRst};
    enc_phase = ENC_IDLE;
    enc_shift = '0;
    enc_bit_idx = '0;
    enc_ticks = '0;
    hold_byte = '0;
    hold_full = 1'b0;
    hold_last = 1'b0;
    cur_last = 1'b0;
    line_q = 1'b0;
  endfunction

  function automatic void load_shifter();
    enc_shift = hold_byte;
    cur_last = hold_last;
    hold_full = 1'b0;
    enc_bit_idx = 3'd7;
    enc_ticks = '0;
  endfunction

  function automatic out_item_t encode_beat(in_item_t b);
    out_item_t r;
    logic [7:0] high;
    r = '0;
    if (b.func == FUNC_PUSH) begin
      if (hold_full) begin
        r.overrun = 1'b1;
      end else begin
        hold_byte = b.data_byte;
        hold_last = b.last_byte;
        hold_full = 1'b1;
      end
    end else begin
      case (enc_phase)
        ENC_RESET: begin
          line_q = 1'b0;
          enc_ticks = enc_ticks + 16'd1;
          if (enc_ticks >= timing.reset_ticks) begin
            enc_phase = ENC_SEND;
            enc_ticks = '0;
            enc_bit_idx = 3'd7;
          end
        end
        ENC_SEND: begin
          high = enc_shift[enc_bit_idx] ? timing.one_high_ticks : timing.zero_high_ticks;
          line_q = (enc_ticks < {8'd0, high});
          enc_ticks = enc_ticks + 16'd1;
          if (enc_ticks >= {8'd0, timing.bit_ticks}) begin
            enc_ticks = '0;
            if (enc_bit_idx != 3'd0) begin
              enc_bit_idx = enc_bit_idx - 3'd1;
            end else if (cur_last) begin
              enc_phase = ENC_IDLE;
            end else if (hold_full) begin
              load_shifter();
            end else begin
              r.underrun = 1'b1;
              enc_phase = ENC_IDLE;
            end
          end
        end
        default: begin
          // A tick that finds a byte waiting opens the frame with its reset phase.
          enc_phase = ENC_IDLE;
          line_q = 1'b0;
          if (hold_full) begin
            load_shifter();
            enc_phase = ENC_RESET;
            enc_ticks = 16'd1;
            if (enc_ticks >= timing.reset_ticks) begin
              enc_phase = ENC_SEND;
              enc_ticks = '0;
            end
          end
        end
      endcase
    end
    r.line_level = line_q;
    r.ready_res = !hold_full;
    r.busy_res = (enc_phase == ENC_RESET) || (enc_phase == ENC_SEND);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_t sel, logic [15:0] val);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t beat_row(logic func, logic [7:0] data, logic last,
                                        logic [7:0] reps);
    dir_row_t row;
    row = '0;
    row.beat = '{func: func, data_byte: data, last_byte: last};
    row.reps = reps;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic func, logic [7:0] data, logic last,
                                         out_item_t want);
    dir_row_t row;
    row = beat_row(func, data, last, 8'd1);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic logic [15:0] pick_reg_value(cfg_idx_t sel);
    logic [15:0] v;
    v = 16'($urandom_range(0, 65535));
    if (sel == REG_RESET_TICKS) begin
      case ($urandom_range(0, 11))
        0: v = 16'h0000;
        1: v = 16'hFFFF;
        default: v = 16'($urandom_range(1, 12));
      endcase
    end else begin
      // Upper data bits are ignored by the 8-bit registers but still toggled.
      case ($urandom_range(0, 11))
        0: v[7:0] = 8'h00;
        1: v[7:0] = 8'hFF;
        default: v[7:0] = 8'($urandom_range(1, (sel == REG_BIT_TICKS) ? 9 : 7));
      endcase
    end
    return v;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      n_fail++;
    end
  endfunction

  task automatic issue_beat(in_item_t b, logic typed, out_item_t want);
    out_item_t predicted;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    predicted = encode_beat(b);
    line_beats_due.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk) in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 40);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk) in_valid <= 1'b0;
    while (line_beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t sel, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_ZERO_HIGH:   timing.zero_high_ticks = val[7:0];
      REG_ONE_HIGH:    timing.one_high_ticks = val[7:0];
      REG_BIT_TICKS:   timing.bit_ticks = val[7:0];
      REG_RESET_TICKS: timing.reset_ticks = val;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Mostly whole frames: a byte is pushed soon after the holder empties and the
  // final one carries the last mark. Some frames are cut short to force an
  // underrun, and a tenth of the beats are plain noise.
  task automatic run_phase(int idx, int n);
    in_item_t b;
    int frame_left;
    logic broken;
    frame_left = 0;
    broken = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (idx == 1 && i == 40) long_hold_req = 1'b1;
      if (idx == 3 && i == 120) wait_for_results();
      b.func = FUNC_TICK;
      b.data_byte = 8'($urandom_range(0, 255));
      b.last_byte = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        b.func = ($urandom_range(0, 1) != 0) ? FUNC_PUSH : FUNC_TICK;
      end else begin
        if (frame_left == 0 && enc_phase == ENC_IDLE && !hold_full) begin
          frame_left = $urandom_range(1, 5);
          broken = ($urandom_range(0, 5) == 0);
        end
        if (frame_left > 0 && !hold_full && $urandom_range(0, 3) != 0) begin
          b.func = FUNC_PUSH;
          b.last_byte = (frame_left == 1) && !broken;
          frame_left--;
        end
      end
      issue_beat(b, 1'b0, '0);
    end
  endtask

  // The receiver runs in segments of no stall, light stall or heavy stall,
  // and holds off for a long stretch on request.
  initial begin
    int seg_left;
    int rx_mode;
    seg_left = 0;
    rx_mode = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          rx_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (rx_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_item_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (line_beats_due.size() == 0) begin
        $error("result beat arrived with nothing expected");
        n_fail++;
      end else begin
        due = line_beats_due.pop_front();
        check_field("line_level", due.line_level, out_data.line_level);
        check_field("ready_res", due.ready_res, out_data.ready_res);
        check_field("busy_res", due.busy_res, out_data.busy_res);
        check_field("overrun", due.overrun, out_data.overrun);
        check_field("underrun", due.underrun, out_data.underrun);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_led_chain_serial_encoder failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_encoder_model();

    // Overrun on a full holder, a frame start under a maximal reset length,
    // then every register at an extreme: zero reset length, a bit period of
    // one tick, high time over the period, back-to-back bytes and an underrun.
    dir_rows.push_back(typed_row(FUNC_TICK, 8'h00, 1'b0, IdleLine));
    dir_rows.push_back(typed_row(FUNC_PUSH, 8'hFF, 1'b0, HeldByte));
    dir_rows.push_back(typed_row(FUNC_PUSH, 8'h00, 1'b1, Dropped));
    dir_rows.push_back(cfg_row(REG_RESET_TICKS, 16'hFFFF));
    dir_rows.push_back(typed_row(FUNC_TICK, 8'h00, 1'b0, FrameStart));
    dir_rows.push_back(beat_row(FUNC_TICK, 8'h00, 1'b0, 8'd1));
    dir_rows.push_back(cfg_row(REG_RESET_TICKS, 16'h0000));
    dir_rows.push_back(cfg_row(REG_BIT_TICKS, 16'h0000));
    dir_rows.push_back(cfg_row(REG_ZERO_HIGH, 16'h0000));
    dir_rows.push_back(cfg_row(REG_ONE_HIGH, 16'h00FF));
    dir_rows.push_back(beat_row(FUNC_PUSH, 8'h00, 1'b0, 8'd1));
    dir_rows.push_back(beat_row(FUNC_TICK, 8'h00, 1'b0, 8'd17));
    dir_rows.push_back(typed_row(FUNC_TICK, 8'h00, 1'b0, IdleLine));

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        wait_for_results();
        write_reg(dir_rows[k].reg_sel, dir_rows[k].reg_val);
      end else begin
        repeat (dir_rows[k].reps) issue_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      wait_for_results();
      write_reg(REG_ZERO_HIGH, pick_reg_value(REG_ZERO_HIGH));
      write_reg(REG_ONE_HIGH, pick_reg_value(REG_ONE_HIGH));
      write_reg(REG_BIT_TICKS, pick_reg_value(REG_BIT_TICKS));
      write_reg(REG_RESET_TICKS, pick_reg_value(REG_RESET_TICKS));
      run_phase(p, PhaseItems);
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_led_chain_serial_encoder passed");
    end else begin
      $display("tb_led_chain_serial_encoder failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lce_pkg.sv
hw/rtl/lce_cfg.sv
hw/rtl/lce_core.sv
hw/rtl/led_chain_serial_encoder.sv
bench/tb_led_chain_serial_encoder.sv
